// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros included by the RTL top level.
// Concurrent checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed")

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed")

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Types and constants of the cellular signal converter.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  // Technology codes of a report
  localparam logic [2:0] TECH_GSM   = 3'd0;
  localparam logic [2:0] TECH_EDGE  = 3'd1;
  localparam logic [2:0] TECH_UTRAN = 3'd2;
  localparam logic [2:0] TECH_LTE   = 3'd3;
  localparam logic [2:0] TECH_CATM1 = 3'd4;
  localparam logic [2:0] TECH_NB1   = 3'd5;

  // Access technology codes of a result
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_GSM   = 3'd1;
  localparam logic [2:0] ACT_EGPRS = 3'd2;
  localparam logic [2:0] ACT_UMTS  = 3'd3;
  localparam logic [2:0] ACT_LTE   = 3'd4;
  localparam logic [2:0] ACT_CATM1 = 3'd5;
  localparam logic [2:0] ACT_NB1   = 3'd6;

  localparam logic signed [31:0] UNKNOWN_VAL = 32'sh8000_0000;
  localparam logic [15:0]        SCALE_MAX   = 16'hFFFF;

  // Reciprocal shift: x * ceil(2^31/d) >> 31 is exact for x < 2^23, d < 2^7
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 29;
  localparam int SCALE_X_W   = 23;
  localparam int SCALE_P_W   = SCALE_X_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_7  = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7);
  localparam logic [RECIP_W-1:0] RECIP_34 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd33) / 64'd34);
  localparam logic [RECIP_W-1:0] RECIP_49 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd48) / 64'd49);
  localparam logic [RECIP_W-1:0] RECIP_63 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd62) / 64'd63);
  localparam logic [RECIP_W-1:0] RECIP_96 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd95) / 64'd96);
  localparam logic [RECIP_W-1:0] RECIP_97 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd96) / 64'd97);

  // How an output value is formed
  typedef enum logic [1:0] {
    VM_ZERO    = 2'd0,
    VM_VALUE   = 2'd1,
    VM_SAT     = 2'd2,
    VM_UNKNOWN = 2'd3
  } csc_mode_t;

  // Divisor of a 0..65535 scaling
  typedef enum logic [2:0] {
    DEN_7  = 3'd0,
    DEN_34 = 3'd1,
    DEN_49 = 3'd2,
    DEN_63 = 3'd3,
    DEN_96 = 3'd4,
    DEN_97 = 3'd5
  } csc_den_t;

  typedef struct packed {
    logic              report_ok;
    logic [2:0]        technology;
    logic signed [7:0] raw_rssi;
    logic signed [7:0] raw_qual;
    logic [6:0]        rx_level;
    logic [6:0]        rx_quality;
    logic [7:0]        umts_rscp;
    logic [7:0]        umts_ecno;
    logic [7:0]        lte_rsrp;
    logic [7:0]        lte_rsrq;
  } csc_report_t;

  typedef struct packed {
    logic               error;
    logic [2:0]         access_tech;
    logic signed [7:0]  pass_rssi;
    logic signed [7:0]  pass_qual;
    logic signed [31:0] level_centi;
    logic signed [31:0] quality_centi;
    logic signed [31:0] strength_scaled;
    logic signed [31:0] quality_scaled;
  } csc_result_t;

  // Fields that only travel alongside the arithmetic
  typedef struct packed {
    logic              error;
    logic [2:0]        access_tech;
    logic signed [7:0] pass_rssi;
    logic signed [7:0] pass_qual;
  } csc_hdr_t;

  // Level and quality in hundredths
  typedef struct packed {
    csc_mode_t          lev_mode;
    logic signed [8:0]  lev_diff;
    csc_mode_t          qc_mode;
    logic               qc_direct;
    logic signed [11:0] qc_val;
    logic [7:0]         qc_code;
    logic [11:0]        qc_off;
  } csc_lq_req_t;

  // One 0..65535 scaling: num is at most the divisor when mode is VM_VALUE
  typedef struct packed {
    csc_mode_t  mode;
    csc_den_t   den;
    logic [6:0] num;
  } csc_scale_req_t;

  typedef struct packed {
    csc_hdr_t       hdr;
    csc_lq_req_t    lq;
    csc_scale_req_t st;
    csc_scale_req_t qs;
  } csc_s1_t;

  function automatic logic [RECIP_W-1:0] csc_recip(input csc_den_t den);
    logic [RECIP_W-1:0] r;
    case (den)
      DEN_7:   r = RECIP_7;
      DEN_34:  r = RECIP_34;
      DEN_49:  r = RECIP_49;
      DEN_63:  r = RECIP_63;
      DEN_96:  r = RECIP_96;
      DEN_97:  r = RECIP_97;
      default: r = RECIP_7;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/csc_decode.sv
// ----------------------------------------------------------------------------
// csc_decode
// First stage: pick the codes that the technology uses and classify them.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire csc_pkg::csc_report_t report,
  output csc_pkg::csc_s1_t          s1,
  output logic                      s1_valid
);
  import csc_pkg::*;

  localparam logic [6:0] GSM_UNKNOWN = 7'd99;
  localparam logic [7:0] CODE_UNKNOWN = 8'd255;

  csc_s1_t s1_next;

  // GSM bit error rate in hundredths of a percent
  function automatic logic signed [11:0] ber_centi(input logic [2:0] q);
    logic signed [11:0] v;
    case (q)
      3'd0:    v = 12'sd14;
      3'd1:    v = 12'sd28;
      3'd2:    v = 12'sd57;
      3'd3:    v = 12'sd113;
      3'd4:    v = 12'sd226;
      3'd5:    v = 12'sd453;
      3'd6:    v = 12'sd905;
      3'd7:    v = 12'sd1810;
      default: v = 12'sd14;
    endcase
    return v;
  endfunction

  // EDGE bit error probability, already in log10 hundredths
  function automatic logic signed [11:0] bep_centi(input logic [2:0] q);
    logic signed [11:0] v;
    case (q)
      3'd0:    v = -12'sd370;
      3'd1:    v = -12'sd320;
      3'd2:    v = -12'sd280;
      3'd3:    v = -12'sd230;
      3'd4:    v = -12'sd190;
      3'd5:    v = -12'sd140;
      3'd6:    v = -12'sd100;
      3'd7:    v = -12'sd60;
      default: v = -12'sd370;
    endcase
    return v;
  endfunction

  logic [8:0] rscp_p5;

  always_comb begin
    rscp_p5 = {1'b0, report.umts_rscp} + 9'd5;
    s1_next = '0;
    s1_next.hdr.pass_rssi = report.raw_rssi;
    s1_next.hdr.pass_qual = report.raw_qual;
    if (!report.report_ok) begin
      // failed query: error and nothing else
      s1_next.hdr = '0;
      s1_next.hdr.error = 1'b1;
    end else begin
      case (report.technology)
        TECH_GSM, TECH_EDGE: begin
          s1_next.hdr.access_tech = (report.technology == TECH_GSM) ? ACT_GSM : ACT_EGPRS;
          if (report.rx_level != GSM_UNKNOWN) begin
            s1_next.lq.lev_mode = VM_VALUE;
            s1_next.lq.lev_diff = $signed({2'b00, report.rx_level}) - 9'sd111;
            s1_next.st.mode = (report.rx_level > 7'd63) ? VM_SAT : VM_VALUE;
          end else begin
            s1_next.lq.lev_mode = VM_UNKNOWN;
            s1_next.st.mode = VM_UNKNOWN;
          end
          s1_next.st.den = DEN_63;
          s1_next.st.num = report.rx_level;
          if (report.rx_quality <= 7'd7) begin
            s1_next.lq.qc_mode = VM_VALUE;
            s1_next.lq.qc_direct = 1'b1;
            s1_next.lq.qc_val = (report.technology == TECH_GSM) ?
                                ber_centi(report.rx_quality[2:0]) :
                                bep_centi(report.rx_quality[2:0]);
            s1_next.qs.mode = VM_VALUE;
          end else begin
            s1_next.lq.qc_mode = VM_UNKNOWN;
            s1_next.qs.mode = VM_UNKNOWN;
          end
          s1_next.qs.den = DEN_7;
          s1_next.qs.num = 7'd7 - report.rx_quality;
        end
        TECH_UTRAN: begin
          s1_next.hdr.access_tech = ACT_UMTS;
          if (report.umts_rscp != CODE_UNKNOWN) begin
            s1_next.lq.lev_mode = VM_VALUE;
            s1_next.lq.lev_diff = $signed({1'b0, report.umts_rscp}) - 9'sd116;
            s1_next.st.mode = (rscp_p5 > 9'd96) ? VM_SAT : VM_VALUE;
          end else begin
            s1_next.lq.lev_mode = VM_UNKNOWN;
            s1_next.st.mode = VM_UNKNOWN;
          end
          s1_next.st.den = DEN_96;
          s1_next.st.num = rscp_p5[6:0];
          if (report.umts_ecno != CODE_UNKNOWN) begin
            s1_next.lq.qc_mode = VM_VALUE;
            s1_next.qs.mode = (report.umts_ecno > 8'd49) ? VM_SAT : VM_VALUE;
          end else begin
            s1_next.lq.qc_mode = VM_UNKNOWN;
            s1_next.qs.mode = VM_UNKNOWN;
          end
          s1_next.lq.qc_code = report.umts_ecno;
          s1_next.lq.qc_off = 12'd2450;
          s1_next.qs.den = DEN_49;
          s1_next.qs.num = report.umts_ecno[6:0];
        end
        TECH_LTE, TECH_CATM1, TECH_NB1: begin
          case (report.technology)
            TECH_LTE:   s1_next.hdr.access_tech = ACT_LTE;
            TECH_CATM1: s1_next.hdr.access_tech = ACT_CATM1;
            default:    s1_next.hdr.access_tech = ACT_NB1;
          endcase
          if (report.lte_rsrp != CODE_UNKNOWN) begin
            s1_next.lq.lev_mode = VM_VALUE;
            s1_next.lq.lev_diff = $signed({1'b0, report.lte_rsrp}) - 9'sd141;
            s1_next.st.mode = (report.lte_rsrp > 8'd97) ? VM_SAT : VM_VALUE;
          end else begin
            s1_next.lq.lev_mode = VM_UNKNOWN;
            s1_next.st.mode = VM_UNKNOWN;
          end
          s1_next.st.den = DEN_97;
          s1_next.st.num = report.lte_rsrp[6:0];
          if (report.lte_rsrq != CODE_UNKNOWN) begin
            s1_next.lq.qc_mode = VM_VALUE;
            s1_next.qs.mode = (report.lte_rsrq > 8'd34) ? VM_SAT : VM_VALUE;
          end else begin
            s1_next.lq.qc_mode = VM_UNKNOWN;
            s1_next.qs.mode = VM_UNKNOWN;
          end
          s1_next.lq.qc_code = report.lte_rsrq;
          s1_next.lq.qc_off = 12'd2000;
          s1_next.qs.den = DEN_34;
          s1_next.qs.num = report.lte_rsrq[6:0];
        end
        default: begin
          // unrecognised technology: raw values pass, levels unknown
          s1_next.hdr.error = 1'b1;
          s1_next.hdr.access_tech = ACT_NONE;
          s1_next.lq.lev_mode = VM_UNKNOWN;
          s1_next.lq.qc_mode = VM_UNKNOWN;
          s1_next.st.mode = VM_ZERO;
          s1_next.qs.mode = VM_ZERO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    s1 <= s1_next;
  end

endmodule

`default_nettype wire

// File: rtl/csc_level.sv
// ----------------------------------------------------------------------------
// csc_level
// Level in dBm hundredths and quality in hundredths, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_level (
  input  wire logic                 clk,
  input  wire csc_pkg::csc_lq_req_t req,
  output logic signed [31:0]        level_centi,
  output logic signed [31:0]        quality_centi
);
  import csc_pkg::*;

  logic signed [15:0] lev_prod;
  logic signed [14:0] qc_lin;
  logic signed [15:0] lev_a;
  logic signed [14:0] qc_a;
  csc_mode_t          lev_mode_a;
  csc_mode_t          qc_mode_a;
  logic signed [31:0] level_next;
  logic signed [31:0] quality_next;

  always_comb begin
    lev_prod = 16'(req.lev_diff) * 16'sd100;
    qc_lin = $signed({1'b0, 14'(req.qc_code) * 14'd50}) - $signed(15'(req.qc_off));
  end

  // stage A: scale by constants
  always_ff @(posedge clk) begin
    lev_a <= lev_prod;
    qc_a <= req.qc_direct ? 15'(req.qc_val) : qc_lin;
    lev_mode_a <= req.lev_mode;
    qc_mode_a <= req.qc_mode;
  end

  always_comb begin
    case (lev_mode_a)
      VM_VALUE:   level_next = 32'(lev_a);
      VM_UNKNOWN: level_next = UNKNOWN_VAL;
      default:    level_next = '0;
    endcase
    case (qc_mode_a)
      VM_VALUE:   quality_next = 32'(qc_a);
      VM_UNKNOWN: quality_next = UNKNOWN_VAL;
      default:    quality_next = '0;
    endcase
  end

  // stage B: widen and mark unknowns
  always_ff @(posedge clk) begin
    level_centi <= level_next;
    quality_centi <= quality_next;
  end

endmodule

`default_nettype wire

// File: rtl/csc_scale.sv
// ----------------------------------------------------------------------------
// csc_scale
// num * 65535 / den by reciprocal multiplication, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_scale (
  input  wire logic                    clk,
  input  wire csc_pkg::csc_scale_req_t req,
  output logic signed [31:0]           value
);
  import csc_pkg::*;

  logic [SCALE_X_W-1:0] x_a;
  csc_den_t             den_a;
  csc_mode_t            mode_a;
  logic [SCALE_P_W-1:0] prod_b;
  csc_mode_t            mode_b;

  // stage A: num * 65535 as a shift and subtract
  always_ff @(posedge clk) begin
    x_a <= {req.num, 16'd0} - SCALE_X_W'(req.num);
    den_a <= req.den;
    mode_a <= req.mode;
  end

  // stage B: multiply by the rounded-up reciprocal of the divisor
  always_ff @(posedge clk) begin
    prod_b <= SCALE_P_W'(x_a) * SCALE_P_W'(csc_recip(den_a));
    mode_b <= mode_a;
  end

  always_comb begin
    case (mode_b)
      VM_VALUE:   value = {16'd0, prod_b[RECIP_SHIFT+15:RECIP_SHIFT]};
      VM_SAT:     value = {16'd0, SCALE_MAX};
      VM_UNKNOWN: value = UNKNOWN_VAL;
      default:    value = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/cellular_signal_converter_top.sv
// ----------------------------------------------------------------------------
// cellular_signal_converter_top
// Converts one raw modem signal report per cycle into scaled level and
// quality values.
// ----------------------------------------------------------------------------
// A report taken at one clock edge has its result on the result ports
//   (strobe high) once it has passed the decode, scaling, multiply and output registers.
// Throughput: one report every cycle; a four-register pipeline (decode,
//   constant scaling, reciprocal multiply, output) sets the figure.
// busy is high only while rst is high; results are never held off.
// Reset clears the valid bits of every stage; payload registers keep data.
`default_nettype none

`include "assert_macros.svh"

module cellular_signal_converter_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire csc_pkg::csc_report_t report,
  output logic                      strobe,
  output csc_pkg::csc_result_t      result
);
  import csc_pkg::*;

  logic               take;
  csc_s1_t            s1;
  logic               s1_valid;
  // header fields ride alongside the arithmetic stages
  csc_hdr_t           hdr2;
  csc_hdr_t           hdr3;
  logic               v2;
  logic               v3;
  logic signed [31:0] level_centi;
  logic signed [31:0] quality_centi;
  logic signed [31:0] strength_scaled;
  logic signed [31:0] quality_scaled;

  // take a report whenever one is offered outside reset
  assign busy = rst;
  assign take = start && !busy;

  // stage 1: select and classify the codes of the technology
  csc_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .report   (report),
    .s1       (s1),
    .s1_valid (s1_valid)
  );

  // stages 2 and 3: level and quality in hundredths
  csc_level u_level (
    .clk           (clk),
    .req           (s1.lq),
    .level_centi   (level_centi),
    .quality_centi (quality_centi)
  );

  // stages 2 and 3: strength on 0..65535
  csc_scale u_strength (
    .clk   (clk),
    .req   (s1.st),
    .value (strength_scaled)
  );

  // stages 2 and 3: quality on 0..65535
  csc_scale u_quality (
    .clk   (clk),
    .req   (s1.qs),
    .value (quality_scaled)
  );

  // advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v2 <= s1_valid;
      v3 <= v2;
      strobe <= v3;
    end
    hdr2 <= s1.hdr;
    hdr3 <= hdr2;
  end

  // stage 4: hold the finished item on the result ports for one cycle
  always_ff @(posedge clk) begin
    result.error <= hdr3.error;
    result.access_tech <= hdr3.access_tech;
    result.pass_rssi <= hdr3.pass_rssi;
    result.pass_qual <= hdr3.pass_qual;
    result.level_centi <= level_centi;
    result.quality_centi <= quality_centi;
    result.strength_scaled <= strength_scaled;
    result.quality_scaled <= quality_scaled;
  end

  `ASSERT_IMPLIES(a_latency, clk, rst, take, ##4 strobe);
  `ASSERT_IMPLIES(a_no_phantom, clk, rst, strobe, $past(take, 4));
  `ASSERT_IMPLIES(a_error_no_tech, clk, rst, strobe && result.error,
                  result.access_tech == ACT_NONE);
  `ASSERT_IMPLIES(a_strength_range, clk, rst, strobe && !result.strength_scaled[31],
                  result.strength_scaled[30:16] == 15'd0);

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of cellular_signal_converter_top
// Drives modem signal reports through the start/busy handshake, predicts the
// converted level and quality values of each accepted item, and checks every
// strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

  import csc_pkg::*;

  // Sentinel codes for "not known" in the raw report
  localparam int RXLEV_UNKNOWN = 99;
  localparam int CODE_UNKNOWN  = 255;
  // Highest code each field is specified for
  localparam int RXLEV_STD_MAX = 63;
  localparam int RXQUAL_STD_MAX = 7;
  localparam int RSCP_STD_MAX  = 91;
  localparam int ECNO_STD_MAX  = 49;
  localparam int RSRP_STD_MAX  = 97;
  localparam int RSRQ_STD_MAX  = 34;

  localparam int MAX_GAP      = 17;
  localparam int STALL_LIMIT  = 250;   // longest gap plus pipeline, many times over
  localparam int DRAIN_CYCLES = 12;    // margin for stray results once the queue is empty
  localparam int RANDOM_ITEMS = 1430;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        strobe;
  csc_report_t report;
  csc_result_t result;

  csc_result_t predicted_results[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  bit          back_to_back   = 1'b0;

  cellular_signal_converter_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .report (report),
    .strobe (strobe),
    .result (result)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Map num/den onto 0..65535, clipping codes beyond the standard range
  function automatic int scale_clip(input int num, input int den);
    int v;
    v = num * 65535 / den;
    return (v > 65535) ? 65535 : v;
  endfunction

  // Work out the converted result of one report
  function automatic csc_result_t predict_conversion(input csc_report_t r);
    csc_result_t res;
    int lev_c, qual_c, str_s, qual_s;
    int rxlev, rxq, rscp, ecno, rsrp, rsrq, bep;
    res = '0;
    // A failed strength query zeroes everything but the error flag
    if (!r.report_ok) begin
      res.error = 1'b1;
      return res;
    end
    rxlev  = r.rx_level;
    rxq    = r.rx_quality;
    rscp   = r.umts_rscp;
    ecno   = r.umts_ecno;
    rsrp   = r.lte_rsrp;
    rsrq   = r.lte_rsrq;
    lev_c  = UNKNOWN_VAL;
    qual_c = UNKNOWN_VAL;
    str_s  = UNKNOWN_VAL;
    qual_s = UNKNOWN_VAL;
    res.pass_rssi = r.raw_rssi;
    res.pass_qual = r.raw_qual;
    case (r.technology)
      TECH_GSM, TECH_EDGE: begin
        res.access_tech = (r.technology == TECH_GSM) ? ACT_GSM : ACT_EGPRS;
        if (rxlev != RXLEV_UNKNOWN) begin
          lev_c = (rxlev - 111) * 100;
          str_s = scale_clip(rxlev, 63);
        end
        // Any RXQUAL beyond the standard range reads as unknown
        if (rxq <= RXQUAL_STD_MAX) begin
          if (r.technology == TECH_GSM) begin
            case (rxq)
              0: qual_c = 14;
              1: qual_c = 28;
              2: qual_c = 57;
              3: qual_c = 113;
              4: qual_c = 226;
              5: qual_c = 453;
              6: qual_c = 905;
              default: qual_c = 1810;
            endcase
          end else begin
            bep    = (7 - rxq) * 31 / 7;
            qual_c = (31 - bep) * 10 - 370;
          end
          qual_s = (7 - rxq) * 65535 / 7;
        end
      end
      TECH_UTRAN: begin
        res.access_tech = ACT_UMTS;
        if (rscp != CODE_UNKNOWN) begin
          lev_c = (rscp - 116) * 100;
          str_s = scale_clip(rscp + 5, 96);
        end
        if (ecno != CODE_UNKNOWN) begin
          qual_c = ecno * 50 - 2450;
          qual_s = scale_clip(ecno, 49);
        end
      end
      TECH_LTE, TECH_CATM1, TECH_NB1: begin
        case (r.technology)
          TECH_LTE:   res.access_tech = ACT_LTE;
          TECH_CATM1: res.access_tech = ACT_CATM1;
          default:    res.access_tech = ACT_NB1;
        endcase
        if (rsrp != CODE_UNKNOWN) begin
          lev_c = (rsrp - 141) * 100;
          str_s = scale_clip(rsrp, 97);
        end
        if (rsrq != CODE_UNKNOWN) begin
          qual_c = rsrq * 50 - 2000;
          qual_s = scale_clip(rsrq, 34);
        end
      end
      default: begin
        // Unknown technology: flag it, keep the raw pass-through values
        res.error       = 1'b1;
        res.access_tech = ACT_NONE;
        str_s           = 0;
        qual_s          = 0;
      end
    endcase
    res.level_centi     = lev_c;
    res.quality_centi   = qual_c;
    res.strength_scaled = str_s;
    res.quality_scaled  = qual_s;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(input csc_result_t want, input csc_result_t got);
    check_field("error",           want.error,           got.error);
    check_field("access_tech",     want.access_tech,     got.access_tech);
    check_field("pass_rssi",       want.pass_rssi,       got.pass_rssi);
    check_field("pass_qual",       want.pass_qual,       got.pass_qual);
    check_field("level_centi",     want.level_centi,     got.level_centi);
    check_field("quality_centi",   want.quality_centi,   got.quality_centi);
    check_field("strength_scaled", want.strength_scaled, got.strength_scaled);
    check_field("quality_scaled",  want.quality_scaled,  got.quality_scaled);
  endtask

  // Sample at the rising edge: match a strobed result first, then record the
  // prediction of an item taken at this edge (it cannot come out at once).
  always @(posedge clk) begin
    logic took_item;
    took_item = (start === 1'b1) && (busy === 1'b0);
    if (strobe === 1'b1) begin
      if (predicted_results.size() == 0) begin
        $error("result strobed with no report waiting");
        mismatch_count++;
      end else begin
        compare_result(predicted_results.pop_front(), result);
      end
    end
    if (took_item)
      predicted_results.push_back(predict_conversion(report));
    // Count cycles in which nothing moves either way
    if (took_item || strobe === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
  end

  // Watchdog: stop a run that has hung
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one item at the falling edge and hold it until it is taken. Keep
  // start high when the next item follows with no gap.
  task automatic send_report(input csc_report_t item);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    report <= item;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Every bit of every field at random
  function automatic csc_report_t random_report();
    csc_report_t r;
    r.report_ok  = 1'($urandom_range(0, 1));
    r.technology = 3'($urandom_range(0, 7));
    r.raw_rssi   = 8'($urandom_range(0, 255));
    r.raw_qual   = 8'($urandom_range(0, 255));
    r.rx_level   = 7'($urandom_range(0, 127));
    r.rx_quality = 7'($urandom_range(0, 127));
    r.umts_rscp  = 8'($urandom_range(0, 255));
    r.umts_ecno  = 8'($urandom_range(0, 255));
    r.lte_rsrp   = 8'($urandom_range(0, 255));
    r.lte_rsrq   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Mostly codes in the standard range, some sentinels, some anything
  function automatic logic [7:0] pick_code(input int std_max, input int sentinel,
                                           input int field_max);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return 8'(sentinel);
    if (roll == 1)
      return 8'($urandom_range(0, field_max));
    return 8'($urandom_range(0, std_max));
  endfunction

  // A report that mostly succeeds with a known technology
  function automatic csc_report_t shaped_report();
    csc_report_t r;
    r            = random_report();
    r.report_ok  = ($urandom_range(0, 19) != 0);
    r.technology = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
    r.rx_level   = 7'(pick_code(RXLEV_STD_MAX, RXLEV_UNKNOWN, 127));
    r.rx_quality = 7'(pick_code(RXQUAL_STD_MAX, RXLEV_UNKNOWN, 127));
    r.umts_rscp  = pick_code(RSCP_STD_MAX, CODE_UNKNOWN, 255);
    r.umts_ecno  = pick_code(ECNO_STD_MAX, CODE_UNKNOWN, 255);
    r.lte_rsrp   = pick_code(RSRP_STD_MAX, CODE_UNKNOWN, 255);
    r.lte_rsrq   = pick_code(RSRQ_STD_MAX, CODE_UNKNOWN, 255);
    return r;
  endfunction

  // Send a good report of one technology with its strength and quality codes
  task automatic send_codes(input logic [2:0] tech, input int strength_code,
                            input int quality_code);
    csc_report_t r;
    r            = random_report();
    r.report_ok  = 1'b1;
    r.technology = tech;
    case (tech)
      TECH_GSM, TECH_EDGE: begin
        r.rx_level   = 7'(strength_code);
        r.rx_quality = 7'(quality_code);
      end
      TECH_UTRAN: begin
        r.umts_rscp = 8'(strength_code);
        r.umts_ecno = 8'(quality_code);
      end
      default: begin
        r.lte_rsrp = 8'(strength_code);
        r.lte_rsrq = 8'(quality_code);
      end
    endcase
    send_report(r);
  endtask

  // Failed query: every field but the error flag must be zero
  task automatic test_failed_reports();
    csc_report_t r;
    r            = random_report();
    r.report_ok  = 1'b0;
    r.technology = TECH_UTRAN;
    r.raw_rssi   = -8'sd128;
    r.raw_qual   = 8'sd127;
    send_report(r);
    r            = random_report();
    r.report_ok  = 1'b0;
    r.technology = 3'd7;
    r.raw_rssi   = 8'sd127;
    r.raw_qual   = -8'sd128;
    send_report(r);
  endtask

  // Technology codes beyond NB1: error, raw values still pass through
  task automatic test_unknown_technology();
    csc_report_t r;
    r            = random_report();
    r.report_ok  = 1'b1;
    r.technology = 3'd6;
    r.raw_rssi   = -8'sd128;
    r.raw_qual   = 8'sd127;
    send_report(r);
    r            = random_report();
    r.report_ok  = 1'b1;
    r.technology = 3'd7;
    r.raw_rssi   = 8'sd127;
    r.raw_qual   = -8'sd128;
    send_report(r);
  endtask

  // RXLEV limits, sentinel and out of range; RXQUAL table ends and bad codes
  task automatic test_gsm_edge_codes();
    send_codes(TECH_GSM,  0,             0);
    send_codes(TECH_GSM,  RXLEV_STD_MAX, RXQUAL_STD_MAX);
    send_codes(TECH_GSM,  RXLEV_UNKNOWN, 8);
    send_codes(TECH_GSM,  127,           RXLEV_UNKNOWN);
    send_codes(TECH_EDGE, 64,            0);
    send_codes(TECH_EDGE, 0,             3);
    send_codes(TECH_EDGE, RXLEV_STD_MAX, RXQUAL_STD_MAX);
    send_codes(TECH_EDGE, RXLEV_UNKNOWN, 127);
  endtask

  // RSCP and Ec/No at the ends, beyond them and unknown
  task automatic test_utran_codes();
    send_codes(TECH_UTRAN, 0,            0);
    send_codes(TECH_UTRAN, RSCP_STD_MAX, ECNO_STD_MAX);
    send_codes(TECH_UTRAN, 254,          ECNO_STD_MAX + 1);
    send_codes(TECH_UTRAN, CODE_UNKNOWN, CODE_UNKNOWN);
  endtask

  // RSRP and RSRQ across the three LTE flavours
  task automatic test_lte_codes();
    send_codes(TECH_LTE,   0,                0);
    send_codes(TECH_CATM1, RSRP_STD_MAX,     RSRQ_STD_MAX);
    send_codes(TECH_NB1,   RSRP_STD_MAX + 1, RSRQ_STD_MAX + 1);
    send_codes(TECH_LTE,   CODE_UNKNOWN,     CODE_UNKNOWN);
    send_codes(TECH_NB1,   254,              254);
  endtask

  // Random reports in blocks, some blocks back to back with no gaps at all
  task automatic test_random_reports(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        back_to_back = ($urandom_range(0, 2) == 0);
      send_report(shaped_report());
    end
    back_to_back = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    report = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_failed_reports();
    test_unknown_technology();
    test_gsm_edge_codes();
    test_utran_codes();
    test_lte_codes();
    test_random_reports(RANDOM_ITEMS);

    // Drop start, let the pipeline drain, then allow for stray results
    @(negedge clk);
    start <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_decode.sv
rtl/csc_level.sv
rtl/csc_scale.sv
rtl/cellular_signal_converter_top.sv
sim/tb.sv
